// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the range set RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define CRS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that a trigger is followed in the next cycle by a consequence.
`define CRS_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/crs_pkg.sv =====
// Types and constants of the coalescing range set.
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;
  localparam int POS_W = 48;
  localparam int BS_W = 31;
  localparam int BLK_W = 16;
  localparam int DUMP_MAX = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [BS_W-1:0] BS_RESET = 31'd65536;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [POS_W-1:0] head;
    logic [POS_W-1:0] tail;
  } range_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_LOAD
  } cell_sel_t;

  typedef struct packed {
    logic tail_ge_a;
    logic tail_gt_a;
    logic head_le_a;
    logic head_le_b;
    logic tail_ge_b;
  } cell_flags_t;
endpackage
`default_nettype wire

// ===== rtl/core/crs_cell.sv =====
// One table cell: holds a range, shifts with its neighbors, compares to keys.
`timescale 1ns / 1ps
`default_nettype none
module crs_cell (
  input  wire                       clk,
  input  crs_pkg::cell_sel_t        sel,
  input  crs_pkg::range_t           left_in,
  input  crs_pkg::range_t           right_in,
  input  crs_pkg::range_t           load_in,
  input  wire [crs_pkg::POS_W-1:0]  key_a,
  input  wire [crs_pkg::POS_W-1:0]  key_b,
  output crs_pkg::range_t           data_out,
  output crs_pkg::cell_flags_t      flags
);
  import crs_pkg::*;

  range_t data_r;
  range_t data_nxt;

  always_comb begin
    case (sel)
      CELL_HOLD:  data_nxt = data_r;
      CELL_LEFT:  data_nxt = left_in;
      CELL_RIGHT: data_nxt = right_in;
      CELL_LOAD:  data_nxt = load_in;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out        = data_r;
  assign flags.tail_ge_a = (data_r.tail >= key_a);
  assign flags.tail_gt_a = (data_r.tail > key_a);
  assign flags.head_le_a = (data_r.head <= key_a);
  assign flags.head_le_b = (data_r.head <= key_b);
  assign flags.tail_ge_b = (data_r.tail >= key_b);
endmodule
`default_nettype wire

// ===== rtl/core/crs_div.sv =====
// Restoring divider, one quotient bit a cycle, low quotient bits kept.
`timescale 1ns / 1ps
`default_nettype none
module crs_div (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire [crs_pkg::POS_W-1:0]  dividend,
  input  wire [crs_pkg::BS_W-1:0]   divisor,
  output logic                      busy,
  output logic [crs_pkg::BLK_W-1:0] quot
);
  import crs_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] dvd_r;
  logic [BS_W-1:0]  dsr_r;
  logic [BS_W-1:0]  rem_r;
  logic [BLK_W-1:0] q_r;
  logic [BS_W:0]    trial;
  logic             fits;

  assign trial = {rem_r, dvd_r[POS_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(POS_W);
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[POS_W-2:0], 1'b0};
      rem_r <= fits ? BS_W'(trial - {1'b0, dsr_r}) : BS_W'(trial);
      q_r   <= {q_r[BLK_W-2:0], fits};
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// ===== rtl/core/coalescing_range_set.sv =====
// Top level of the coalescing range set: control, cell row and dividers.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | op, seg_start, seg_size, blocks, last_pair
//  out_    | output    | out_valid/out_stall| status, counts, bytes, needed, blocks, last
//  cfg_    | input     | cfg_valid/cfg_ready| block_size
//
// Insert: an evaluate step (an empty or dropped insert ends there), a shift step for
// each merged range past the first, then a full rotation of the cell row to total
// the held bytes. Query: multiply, compare, result. Dump, for each range: start,
// 48 divide steps, a settle step, output; then rotate steps restore the row order.
// Reset is synchronous; the table comes up empty. A stalled result holds the
// output register and the sequencer waits for it before the next result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module coalescing_range_set #(
  parameter int MAX_RANGES = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [1:0]                  in_op,
  input  wire [crs_pkg::POS_W-1:0]   in_seg_start,
  input  wire [crs_pkg::POS_W-1:0]   in_seg_size,
  input  wire [crs_pkg::BLK_W-1:0]   in_first_block,
  input  wire [crs_pkg::BLK_W-1:0]   in_end_block,
  input  wire                        in_last_pair,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic                       out_status,
  output logic [4:0]                 out_seg_count,
  output logic [crs_pkg::POS_W-1:0]  out_covered_bytes,
  output logic                       out_needed,
  output logic                       out_any_needed,
  output logic [crs_pkg::BLK_W-1:0]  out_part_start_block,
  output logic [crs_pkg::BLK_W-1:0]  out_part_end_block,
  output logic                       out_last,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [crs_pkg::BS_W-1:0]    cfg_data
);
  import crs_pkg::*;

  localparam int CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_EVAL,
    S_INS_SHIFT,
    S_SUM,
    S_QRY_MUL,
    S_QRY_EVAL,
    S_DSTART,
    S_DWAIT,
    S_DOUT,
    S_ROT,
    S_RESULT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [POS_W-1:0] bytes_r, bytes_nxt;
  logic             nacc_r, nacc_nxt;
  logic [BS_W-1:0]  bs_r;
  logic [CW-1:0]    k_r, k_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    sh_r, sh_nxt;
  logic [POS_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0] s_r, e_r, fpos_r, epos_r;
  logic             nop_r, lp_r;
  logic [BLK_W-1:0] fb_r, eb_r;
  logic             st_r, st_nxt, need_r, need_nxt, any_r, any_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_needed_r, out_any_r, out_last_r;
  logic [4:0]       out_cnt_r;
  logic [POS_W-1:0] out_bytes_r;
  logic [BLK_W-1:0] out_ps_r, out_pe_r;
  logic             out_load;
  logic             out_free;

  range_t           cell_data [MAX_RANGES];
  cell_flags_t      cell_flg  [MAX_RANGES];
  cell_sel_t        cell_sel  [MAX_RANGES];
  range_t           merged;
  logic [POS_W-1:0] key_a, key_b;

  logic [MAX_RANGES-1:0] vld, mrg, blw, hit;
  logic [CW-1:0]    lo_c, m_c;
  logic [POS_W-1:0] fhead, ltail;
  logic             qok;

  logic [BS_W-1:0]  bs_eff;
  logic [46:0]      fprod, eprod;
  logic [POS_W:0]   e_sum;
  logic [POS_W:0]   acc_sum;
  logic [7:0]       cnt8, n8;
  logic             dump_last;
  logic             dbusy_s, dbusy_e, dstart;
  logic [BLK_W-1:0] dq_s, dq_e;

  assign bs_eff    = (bs_r == '0) ? BS_W'(1) : bs_r;
  assign fprod     = 47'(fb_r) * 47'(bs_eff);
  assign eprod     = 47'(eb_r) * 47'(bs_eff);
  assign e_sum     = {1'b0, in_seg_start} + {1'b0, in_seg_size};
  assign key_a     = (state_r == S_QRY_EVAL) ? fpos_r : s_r;
  assign key_b     = (state_r == S_QRY_EVAL) ? epos_r : e_r;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign cnt8      = 8'(cnt_r);
  assign n8        = (cnt8 > 8'(DUMP_MAX)) ? 8'(DUMP_MAX) : cnt8;
  assign dump_last = ((8'(k_r) + 8'd1) == n8);
  assign dstart    = (state_r == S_DSTART);
  assign acc_sum   = {1'b0, acc_r} + {1'b0, cell_data[0].tail - cell_data[0].head};

  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    crs_cell u_cell (
      .clk      (clk),
      .sel      (cell_sel[g]),
      .left_in  (cell_data[(g == 0) ? 0 : g - 1]),
      .right_in (cell_data[(g + 1) % MAX_RANGES]),
      .load_in  (merged),
      .key_a    (key_a),
      .key_b    (key_b),
      .data_out (cell_data[g]),
      .flags    (cell_flg[g])
    );
  end

  crs_div u_div_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dstart),
    .dividend (cell_data[0].head),
    .divisor  (bs_eff),
    .busy     (dbusy_s),
    .quot     (dq_s)
  );

  crs_div u_div_e (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dstart),
    .dividend (cell_data[0].tail - POS_W'(1)),
    .divisor  (bs_eff),
    .busy     (dbusy_e),
    .quot     (dq_e)
  );

  // Per-cell compare results, first/last merged range and first hit.
  always_comb begin
    fhead = '0;
    ltail = '0;
    qok   = 1'b0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      vld[i] = (CW'(i) < cnt_r);
      mrg[i] = vld[i] && cell_flg[i].tail_ge_a && cell_flg[i].head_le_b;
      blw[i] = vld[i] && !cell_flg[i].tail_ge_a;
      hit[i] = vld[i] && cell_flg[i].tail_gt_a;
    end
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (mrg[i] && (i == 0 || !mrg[(i == 0) ? 0 : i - 1])) begin
        fhead = fhead | cell_data[i].head;
      end
      if (mrg[i] && (i == MAX_RANGES - 1 || !mrg[(i == MAX_RANGES - 1) ? i : i + 1])) begin
        ltail = ltail | cell_data[i].tail;
      end
      if (hit[i] && (i == 0 || !hit[(i == 0) ? 0 : i - 1])) begin
        qok = qok | (cell_flg[i].head_le_a && cell_flg[i].tail_ge_b);
      end
    end
    lo_c = CW'($countones(blw));
    m_c  = CW'($countones(mrg));
    merged.head = (m_c != '0 && fhead < s_r) ? fhead : s_r;
    merged.tail = (m_c != '0 && ltail > e_r) ? ltail : e_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bytes_nxt     = bytes_r;
    nacc_nxt      = nacc_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    sh_nxt        = sh_r;
    acc_nxt       = acc_r;
    st_nxt        = st_r;
    need_nxt      = need_r;
    any_nxt       = any_r;
    out_load      = 1'b0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      cell_sel[i] = CELL_HOLD;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt   = 1'b0;
          need_nxt = 1'b0;
          any_nxt  = 1'b0;
          case (op_t'(in_op))
            OP_INSERT: state_nxt = S_INS_EVAL;
            OP_QUERY:  state_nxt = S_QRY_MUL;
            OP_DUMP: begin
              k_nxt     = '0;
              state_nxt = (cnt_r == '0) ? S_RESULT : S_DSTART;
            end
            default:   state_nxt = S_RESULT;
          endcase
        end
      end
      S_INS_EVAL: begin
        if (nop_r) begin
          state_nxt = S_RESULT;
        end else if (m_c == '0 && cnt_r >= CW'(MAX_RANGES)) begin
          st_nxt    = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          for (int i = 0; i < MAX_RANGES; i++) begin
            if (CW'(i) == lo_c) begin
              cell_sel[i] = CELL_LOAD;
            end else if (m_c == '0 && CW'(i) > lo_c) begin
              cell_sel[i] = CELL_LEFT;
            end
          end
          cnt_nxt = cnt_r - m_c + CW'(1);
          lo_nxt  = lo_c;
          sh_nxt  = m_c - CW'(1);
          k_nxt   = '0;
          acc_nxt = '0;
          state_nxt = (m_c > CW'(1)) ? S_INS_SHIFT : S_SUM;
        end
      end
      S_INS_SHIFT: begin
        // close the gap left by the absorbed ranges
        for (int i = 0; i < MAX_RANGES; i++) begin
          if (CW'(i) > lo_r) begin
            cell_sel[i] = CELL_RIGHT;
          end
        end
        sh_nxt = sh_r - CW'(1);
        if (sh_r == CW'(1)) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        for (int i = 0; i < MAX_RANGES; i++) begin
          cell_sel[i] = CELL_RIGHT;
        end
        if (k_r < cnt_r) begin
          acc_nxt = acc_sum[POS_W] ? POS_MAX : acc_sum[POS_W-1:0];
        end
        k_nxt = k_r + CW'(1);
        if (k_r == CW'(MAX_RANGES - 1)) begin
          bytes_nxt = acc_nxt;
          state_nxt = S_RESULT;
        end
      end
      S_QRY_MUL: state_nxt = S_QRY_EVAL;
      S_QRY_EVAL: begin
        need_nxt  = !qok;
        any_nxt   = nacc_r | !qok;
        nacc_nxt  = lp_r ? 1'b0 : (nacc_r | !qok);
        state_nxt = S_RESULT;
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (!dbusy_s && !dbusy_e) begin
          state_nxt = S_DOUT;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          for (int i = 0; i < MAX_RANGES; i++) begin
            cell_sel[i] = CELL_RIGHT;
          end
          k_nxt = k_r + CW'(1);
          if (!dump_last) begin
            state_nxt = S_DSTART;
          end else if (k_r == CW'(MAX_RANGES - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ROT;
          end
        end
      end
      S_ROT: begin
        // bring the row back to its original order
        for (int i = 0; i < MAX_RANGES; i++) begin
          cell_sel[i] = CELL_RIGHT;
        end
        k_nxt = k_r + CW'(1);
        if (k_r == CW'(MAX_RANGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      bytes_r     <= '0;
      nacc_r      <= 1'b0;
      bs_r        <= BS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bytes_r     <= bytes_nxt;
      nacc_r      <= nacc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bs_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    lo_r   <= lo_nxt;
    sh_r   <= sh_nxt;
    acc_r  <= acc_nxt;
    st_r   <= st_nxt;
    need_r <= need_nxt;
    any_r  <= any_nxt;
    if (state_r == S_IDLE && in_valid) begin
      s_r   <= in_seg_start;
      e_r   <= e_sum[POS_W] ? POS_MAX : e_sum[POS_W-1:0];
      nop_r <= (in_seg_size == '0) ||
               ((e_sum[POS_W] ? POS_MAX : e_sum[POS_W-1:0]) <= in_seg_start);
      fb_r  <= in_first_block;
      eb_r  <= in_end_block;
      lp_r  <= in_last_pair;
    end
    if (state_r == S_QRY_MUL) begin
      fpos_r <= {1'b0, fprod};
      epos_r <= {1'b0, eprod};
    end
    if (out_load) begin
      out_status_r <= st_r && (state_r == S_RESULT);
      out_cnt_r    <= 5'(cnt_r);
      out_bytes_r  <= bytes_r;
      out_needed_r <= need_r && (state_r == S_RESULT);
      out_any_r    <= any_r && (state_r == S_RESULT);
      if (state_r == S_DOUT) begin
        out_ps_r   <= dq_s;
        out_pe_r   <= dq_e + BLK_W'(1);
        out_last_r <= dump_last;
      end else begin
        out_ps_r   <= '0;
        out_pe_r   <= '0;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_seg_count        = out_cnt_r;
  assign out_covered_bytes    = out_bytes_r;
  assign out_needed           = out_needed_r;
  assign out_any_needed       = out_any_r;
  assign out_part_start_block = out_ps_r;
  assign out_part_end_block   = out_pe_r;
  assign out_last             = out_last_r;

  `CRS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(MAX_RANGES))
  `CRS_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
  `CRS_ASSERT_ALWAYS(a_div_idle, (state_r != S_IDLE) || (!dbusy_s && !dbusy_e))
  `CRS_ASSERT_NEXT(a_drop_no_change, state_r == S_INS_EVAL && state_nxt == S_RESULT,
                   cnt_r == $past(cnt_r))
endmodule
`default_nettype wire

// ===== test/coalescing_range_set_tb.sv =====
// Self-checking testbench for the coalescing range set: predictor, driver and monitor.
`timescale 1ns / 1ps
module coalescing_range_set_tb;
  import crs_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    op_t              op;
    logic [POS_W-1:0] seg_start;
    logic [POS_W-1:0] seg_size;
    logic [BLK_W-1:0] first_block;
    logic [BLK_W-1:0] end_block;
    logic             last_pair;
  } request_t;

  typedef struct {
    logic             status;
    logic [4:0]       seg_count;
    logic [POS_W-1:0] covered_bytes;
    logic             needed;
    logic             any_needed;
    logic [BLK_W-1:0] part_start_block;
    logic [BLK_W-1:0] part_end_block;
    logic             last;
  } result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_op;
  logic [POS_W-1:0] in_seg_start;
  logic [POS_W-1:0] in_seg_size;
  logic [BLK_W-1:0] in_first_block;
  logic [BLK_W-1:0] in_end_block;
  logic in_last_pair;
  logic out_valid;
  logic out_stall;
  logic out_status;
  logic [4:0] out_seg_count;
  logic [POS_W-1:0] out_covered_bytes;
  logic out_needed;
  logic out_any_needed;
  logic [BLK_W-1:0] out_part_start_block;
  logic [BLK_W-1:0] out_part_end_block;
  logic out_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [BS_W-1:0] cfg_data;

  coalescing_range_set uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_seg_start(in_seg_start), .in_seg_size(in_seg_size),
    .in_first_block(in_first_block), .in_end_block(in_end_block),
    .in_last_pair(in_last_pair),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_seg_count(out_seg_count), .out_covered_bytes(out_covered_bytes),
    .out_needed(out_needed), .out_any_needed(out_any_needed),
    .out_part_start_block(out_part_start_block),
    .out_part_end_block(out_part_end_block), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predicted table state
  logic [POS_W-1:0] tbl_start [TABLE_DEPTH];
  logic [POS_W-1:0] tbl_end [TABLE_DEPTH];
  int               tbl_count;
  logic [POS_W-1:0] tbl_bytes;
  logic             need_accum;
  logic [BS_W-1:0]  blk_bytes;

  request_t pending_requests[$];
  result_t  expected_results[$];
  request_t cur_request;
  int       errors;
  int       requests_sent;
  int       results_checked;
  int       settings_used;
  int       burst_left;
  int       gap_left;
  int       stall_mode;
  int       stall_left;
  longint   cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_checked);
    errors++;
  endtask

  function automatic void add_expected(result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic logic [63:0] eff_block();
    return (blk_bytes == 0) ? 64'd1 : {33'd0, blk_bytes};
  endfunction

  function automatic void total_bytes();
    logic [48:0] sum;
    sum = 0;
    for (int k = 0; k < tbl_count; k++) begin
      sum = sum + {1'b0, tbl_end[k] - tbl_start[k]};
      if (sum > {1'b0, POS_MAX}) sum = {1'b0, POS_MAX};
    end
    tbl_bytes = sum[POS_W-1:0];
  endfunction

  function automatic logic merge_range(logic [POS_W-1:0] s, logic [POS_W-1:0] size);
    logic [48:0] e49;
    logic [POS_W-1:0] e, ns, ne;
    logic [POS_W-1:0] ts [TABLE_DEPTH];
    logic [POS_W-1:0] te [TABLE_DEPTH];
    int lo, hi, j;
    if (size == 0) return 1'b0;
    e49 = {1'b0, s} + {1'b0, size};
    e = (e49 > {1'b0, POS_MAX}) ? POS_MAX : e49[POS_W-1:0];
    if (e <= s) return 1'b0;
    lo = 0;
    while (lo < tbl_count && tbl_end[lo] < s) lo++;
    hi = lo;
    ns = s;
    ne = e;
    while (hi < tbl_count && tbl_start[hi] <= e) begin
      if (tbl_start[hi] < ns) ns = tbl_start[hi];
      if (tbl_end[hi] > ne) ne = tbl_end[hi];
      hi++;
    end
    // drop when nothing merges and the table is full
    if (hi == lo && tbl_count >= TABLE_DEPTH) return 1'b1;
    j = 0;
    for (int k = 0; k < lo; k++) begin
      ts[j] = tbl_start[k]; te[j] = tbl_end[k]; j++;
    end
    ts[j] = ns; te[j] = ne; j++;
    for (int k = hi; k < tbl_count; k++) begin
      ts[j] = tbl_start[k]; te[j] = tbl_end[k]; j++;
    end
    for (int k = 0; k < j; k++) begin
      tbl_start[k] = ts[k]; tbl_end[k] = te[k];
    end
    tbl_count = j;
    total_bytes();
    return 1'b0;
  endfunction

  function automatic result_t blank_result();
    result_t r;
    r.status = 0; r.seg_count = tbl_count[4:0]; r.covered_bytes = tbl_bytes;
    r.needed = 0; r.any_needed = 0; r.part_start_block = 0; r.part_end_block = 0;
    r.last = 1;
    return r;
  endfunction

  function automatic void predict_ranges(request_t q);
    result_t r;
    logic [63:0] bs, fpos, epos, ps, pe;
    logic need;
    int i;
    bs = eff_block();
    case (q.op)
      OP_INSERT: begin
        r.status = merge_range(q.seg_start, q.seg_size);
        r = '{r.status, tbl_count[4:0], tbl_bytes, 1'b0, 1'b0, 16'd0, 16'd0, 1'b1};
        add_expected(r);
      end
      OP_QUERY: begin
        fpos = {48'd0, q.first_block} * bs;
        epos = {48'd0, q.end_block} * bs;
        i = 0;
        while (i < tbl_count && {16'd0, tbl_end[i]} <= fpos) i++;
        need = (i >= tbl_count) ||
               !({16'd0, tbl_start[i]} <= fpos && {16'd0, tbl_end[i]} >= epos);
        r = blank_result();
        r.needed = need;
        r.any_needed = need_accum | need;
        need_accum = q.last_pair ? 1'b0 : r.any_needed;
        add_expected(r);
      end
      OP_DUMP: begin
        if (tbl_count == 0) add_expected(blank_result());
        for (int k = 0; k < tbl_count; k++) begin
          ps = {16'd0, tbl_start[k]} / bs;
          pe = ({16'd0, tbl_end[k]} - 64'd1) / bs + 64'd1;
          r = blank_result();
          r.part_start_block = ps[15:0];
          r.part_end_block = pe[15:0];
          r.last = (k + 1 == tbl_count);
          add_expected(r);
        end
      end
      default: add_expected(blank_result());
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand48();
    return POS_W'({$urandom, $urandom});
  endfunction

  task automatic add_request(op_t op, logic [POS_W-1:0] s, logic [POS_W-1:0] size,
                             logic [BLK_W-1:0] fb, logic [BLK_W-1:0] eb, logic lp);
    request_t q;
    q = '{op, s, size, fb, eb, lp};
    pending_requests = {pending_requests, q};
  endtask

  // Mostly well-formed traffic around a base block: overlapping inserts, query lists, dumps, plus idle codes and noise
  task automatic add_random_phase(int count, logic [63:0] bs);
    logic [63:0] base_blk, s, size;
    int pairs, fb, sel;
    base_blk = 64'($urandom_range(0, 60000));
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        s = (base_blk + 64'($urandom_range(0, 96))) * bs + (64'($urandom) % bs);
        size = 64'($urandom_range(1, 8)) * bs + (64'($urandom) % bs);
        if ($urandom_range(0, 3) == 0) size = 64'($urandom_range(1, 40));
        add_request(OP_INSERT, s[POS_W-1:0], size[POS_W-1:0], 0, 0, 0);
      end else if (sel < 75) begin
        pairs = $urandom_range(1, 4);
        for (int p = 0; p < pairs; p++) begin
          fb = int'(base_blk) + int'($urandom_range(0, 100));
          add_request(OP_QUERY, 0, 0, 16'(fb), 16'(fb + int'($urandom_range(0, 5))),
                      p == pairs - 1);
        end
        n += pairs - 1;
      end else if (sel < 83) begin
        add_request(OP_DUMP, 0, 0, 0, 0, 0);
      end else if (sel < 88) begin
        add_request(OP_NONE, rand48(), rand48(), 16'($urandom), 16'($urandom),
                    1'($urandom));
      end else if (sel < 94) begin
        // noise: arbitrary fields, mostly short sizes
        size = 64'(rand48()) >> $urandom_range(0, 47);
        if ($urandom_range(0, 7) == 0) size = 64'(rand48());
        add_request(OP_INSERT, rand48(), size[POS_W-1:0], 16'($urandom), 16'($urandom),
                    1'($urandom));
      end else begin
        add_request(OP_QUERY, rand48(), rand48(), 16'($urandom), 16'($urandom),
                    1'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_block_size(logic [BS_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    blk_bytes = value;
    settings_used++;
  endtask

  // Driver: bursts with random gaps; hold the request while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_ranges(cur_request);
        requests_sent++;
      end
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        cur_request = pending_requests.pop_front();
        in_op <= cur_request.op;
        in_seg_start <= cur_request.seg_start;
        in_seg_size <= cur_request.seg_size;
        in_first_block <= cur_request.first_block;
        in_end_block <= cur_request.end_block;
        in_last_pair <= cur_request.last_pair;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 2))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 6);
            default: gap_left = $urandom_range(5, 40);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest expectation; stall on its own pattern
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_seg_count !== want.seg_count)
          report_mismatch("seg_count", 64'(out_seg_count), 64'(want.seg_count));
        if (out_covered_bytes !== want.covered_bytes)
          report_mismatch("covered_bytes", 64'(out_covered_bytes), 64'(want.covered_bytes));
        if (out_needed !== want.needed)
          report_mismatch("needed", 64'(out_needed), 64'(want.needed));
        if (out_any_needed !== want.any_needed)
          report_mismatch("any_needed", 64'(out_any_needed), 64'(want.any_needed));
        if (out_part_start_block !== want.part_start_block)
          report_mismatch("part_start_block", 64'(out_part_start_block),
                          64'(want.part_start_block));
        if (out_part_end_block !== want.part_end_block)
          report_mismatch("part_end_block", 64'(out_part_end_block),
                          64'(want.part_end_block));
        if (out_last !== want.last) report_mismatch("last", 64'(out_last), 64'(want.last));
      end
      results_checked++;
    end
    if (stall_left <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 8) < 3;
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL coalescing_range_set");
      $finish;
    end
  end

  initial begin
    logic [BS_W-1:0] sizes [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_INSERT;
    in_seg_start = 0;
    in_seg_size = 0;
    in_first_block = 0;
    in_end_block = 0;
    in_last_pair = 0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 0;
    tbl_count = 0;
    tbl_bytes = 0;
    need_accum = 0;
    blk_bytes = BS_RESET;
    errors = 0;
    requests_sent = 0;
    results_checked = 0;
    settings_used = 0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = 0;
    stall_left = 0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty dump and query, an idle code, empty insert, merge cases, saturation, full table
    add_request(OP_DUMP, 0, 0, 0, 0, 0);
    add_request(OP_QUERY, 0, 0, 0, 0, 1);
    add_request(OP_NONE, POS_MAX, POS_MAX, 16'hFFFF, 16'hFFFF, 1);
    add_request(OP_INSERT, 1000, 0, 0, 0, 0);
    add_request(OP_INSERT, 0, 100, 0, 0, 0);
    add_request(OP_INSERT, 100, 50, 0, 0, 0);
    add_request(OP_INSERT, 20, 10, 0, 0, 0);
    add_request(OP_INSERT, 300, 10, 0, 0, 0);
    add_request(OP_INSERT, 140, 200, 0, 0, 0);
    add_request(OP_INSERT, POS_MAX - 5, POS_MAX, 0, 0, 0);
    add_request(OP_QUERY, 0, 0, 0, 0, 0);
    add_request(OP_QUERY, 0, 0, 16'hFFFF, 16'hFFFF, 0);
    add_request(OP_QUERY, 0, 0, 5, 2, 1);
    add_request(OP_DUMP, 0, 0, 0, 0, 0);
    for (int k = 0; k < 15; k++) add_request(OP_INSERT, 48'd100000 * (k + 1), 10, 0, 0, 0);
    add_request(OP_DUMP, 0, 0, 0, 0, 0);
    wait_idle();

    sizes = '{31'd1, 31'd256, 31'd4096, BS_RESET, BS_W'(1 + $urandom_range(0, 1000000)),
              31'd1073741824};
    for (int p = 0; p < 6; p++) begin
      write_block_size(sizes[p]);
      add_random_phase(73, eff_block());
      wait_idle();
    end

    repeat (2000) @(posedge clk);
    $display("%0d requests accepted, %0d results checked, %0d block sizes tried",
             requests_sent, results_checked, settings_used);
    $display("covered inserts with merges and drops, query lists, dumps and idle codes");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS coalescing_range_set");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("FAIL coalescing_range_set");
    end
    $finish;
  end
endmodule
